>>> hw/rtl/tspi_pkg.sv
// Shared types, constants and the divide-by-sixty function for the turret speed PI controller.
// Used by tspi_core and turret_speed_pi_controller; depends on nothing else.
package tspi_pkg;

    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    localparam logic [1:0] CFG_TARGET_PERIOD = 2'd0;
    localparam logic [1:0] CFG_STALL_STEP    = 2'd1;
    localparam logic [1:0] CFG_INTEGRAL_MAX  = 2'd2;

    localparam logic [15:0] STALL_STEP_RESET   = 16'd5000;
    localparam logic [22:0] INTEGRAL_MAX_RESET = 23'd5000000;
    localparam logic [13:0] PROP_MAX           = 14'd16383;
    localparam logic [18:0] TOTAL_MAX          = 19'd16256;
    localparam logic [1:0]  TIMEOUT_RELOAD     = 2'd3;

    // Quotient by 60 as (x >> 2) / 15, the latter by reciprocal multiplication.
    localparam logic [21:0] DIV15_MUL   = 22'd2236963;
    localparam int          DIV15_SHIFT = 25;

    typedef struct packed {
        logic        kind;
        logic [15:0] capture_time;
    } t_item;

    typedef struct packed {
        logic [15:0] target_period;
        logic [15:0] stall_step;
        logic [22:0] integral_max;
    } t_cfg;

    typedef struct packed {
        logic [13:0] prop;
        logic [22:0] integral;
        logic        stalled;
        logic        laser_on;
        logic [15:0] turn_count;
    } t_tick_res;

    function automatic logic [17:0] div60(input logic [22:0] x);
        logic [42:0] prod;
        prod = 43'(x[22:2]) * 43'(DIV15_MUL);
        return prod[DIV15_SHIFT +: 18];
    endfunction

endpackage

>>> hw/rtl/tspi_core.sv
// Controller state and the single-pass PI step: capture bookkeeping, error, proportional term
// and clamped integral. Depends on tspi_pkg.
module tspi_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  tspi_pkg::t_item       i_item,
    input  tspi_pkg::t_cfg        i_cfg,
    output tspi_pkg::t_tick_res   o_res
);

    logic [15:0] r_cur, n_cur;
    logic [15:0] r_prev, n_prev;
    logic [22:0] r_integral, n_integral;
    logic [15:0] r_turns, n_turns;
    logic        r_turn_seen, n_turn_seen;
    logic [1:0]  r_timeout, n_timeout;
    logic        r_laser, n_laser;

    logic signed [15:0] w_err;
    logic signed [24:0] w_addend;
    logic signed [24:0] w_sum;
    logic [13:0]        w_prop;
    logic [22:0]        w_integral;

    always_comb begin
        w_err = signed'(r_cur - r_prev - i_cfg.target_period);
        if (!r_turn_seen) begin
            w_prop   = tspi_pkg::PROP_MAX;
            w_addend = signed'({9'd0, i_cfg.stall_step});
        end else begin
            if (w_err[15]) begin
                w_prop = 14'd0;
            end else if (w_err[14:13] != 2'd0) begin
                w_prop = tspi_pkg::PROP_MAX;
            end else begin
                w_prop = {w_err[12:0], 1'b0};
            end
            w_addend = 25'(w_err);
        end
        w_sum = signed'({2'b00, r_integral}) + w_addend;
        if (w_sum[24]) begin
            w_integral = 23'd0;
        end else if (w_sum[23:0] > {1'b0, i_cfg.integral_max}) begin
            w_integral = i_cfg.integral_max;
        end else begin
            w_integral = w_sum[22:0];
        end
    end

    always_comb begin
        o_res.prop       = w_prop;
        o_res.integral   = w_integral;
        o_res.stalled    = !r_turn_seen;
        o_res.laser_on   = r_laser || (r_timeout != 2'd0);
        o_res.turn_count = r_turns;
    end

    always_comb begin
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_integral  = r_integral;
        n_turns     = r_turns;
        n_turn_seen = r_turn_seen;
        n_timeout   = r_timeout;
        n_laser     = r_laser;
        if (i_fire) begin
            if (i_item.kind == tspi_pkg::KIND_CAPTURE) begin
                n_prev      = r_cur;
                n_cur       = i_item.capture_time;
                n_turns     = r_turns + 16'd1;
                n_turn_seen = 1'b1;
                n_timeout   = tspi_pkg::TIMEOUT_RELOAD;
            end else begin
                n_integral  = w_integral;
                n_turn_seen = 1'b0;
                if (r_timeout != 2'd0) begin
                    n_timeout = r_timeout - 2'd1;
                    n_laser   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= 16'd0;
            r_prev      <= 16'd0;
            r_integral  <= 23'd0;
            r_turns     <= 16'd0;
            r_turn_seen <= 1'b0;
            r_timeout   <= 2'd0;
            r_laser     <= 1'b0;
        end else begin
            r_cur       <= n_cur;
            r_prev      <= n_prev;
            r_integral  <= n_integral;
            r_turns     <= n_turns;
            r_turn_seen <= n_turn_seen;
            r_timeout   <= n_timeout;
            r_laser     <= n_laser;
        end
    end

endmodule

>>> hw/rtl/turret_speed_pi_controller.sv
// Top level of the turret speed PI controller: input register, configuration registers,
// total and duty calculation and the result register. Depends on tspi_pkg and tspi_core.
//
// Channel  Direction  Handshake                 Beat contents
// input    in         i_valid / o_stall         i_kind, i_capture_time
// result   out        o_valid / i_stall         o_duty, o_laser_on, o_turn_count, o_stalled
// config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An input beat is registered in the input register and processed from there; a tick
// delivers its result through the result register, a capture delivers none. One beat per cycle
// is sustained while results are taken. A held result blocks a tick in the input register, which
// then raises o_stall; captures still pass. Reset is synchronous; configuration is always ready.
module turret_speed_pi_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [15:0] i_capture_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_duty,
    output logic        o_laser_on,
    output logic [15:0] o_turn_count,
    output logic        o_stalled,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data
);

    tspi_pkg::t_cfg      r_cfg;
    logic                r_in_valid;
    tspi_pkg::t_item     r_item;
    logic                r_out_valid;
    logic [7:0]          r_duty;
    logic                r_laser;
    logic [15:0]         r_turns;
    logic                r_stalled;

    tspi_pkg::t_tick_res w_res;
    logic                w_out_free;
    logic                w_fire;
    logic                w_tick_fire;
    logic [18:0]         w_total;
    logic [18:0]         w_total_clamped;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_fire      = r_in_valid && ((r_item.kind == tspi_pkg::KIND_CAPTURE) || w_out_free);
    assign w_tick_fire = w_fire && (r_item.kind == tspi_pkg::KIND_TICK);
    assign o_stall     = r_in_valid && !w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_period <= 16'd0;
            r_cfg.stall_step    <= tspi_pkg::STALL_STEP_RESET;
            r_cfg.integral_max  <= tspi_pkg::INTEGRAL_MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tspi_pkg::CFG_TARGET_PERIOD: r_cfg.target_period <= i_cfg_data[15:0];
                tspi_pkg::CFG_STALL_STEP:    r_cfg.stall_step    <= i_cfg_data[15:0];
                tspi_pkg::CFG_INTEGRAL_MAX:  r_cfg.integral_max  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item.kind         <= i_kind;
            r_item.capture_time <= i_capture_time;
        end
    end

    tspi_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_comb begin
        w_total = {5'd0, w_res.prop} + {1'b0, tspi_pkg::div60(w_res.integral)};
        if (w_total > tspi_pkg::TOTAL_MAX) begin
            w_total_clamped = tspi_pkg::TOTAL_MAX;
        end else begin
            w_total_clamped = w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick_fire) begin
            r_duty    <= w_total_clamped[13:6];
            r_laser   <= w_res.laser_on;
            r_turns   <= w_res.turn_count;
            r_stalled <= w_res.stalled;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_duty       = r_duty;
    assign o_laser_on   = r_laser;
    assign o_turn_count = r_turns;
    assign o_stalled    = r_stalled;

    a_duty_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty <= 8'd254))
        else $error("duty beyond its clamped range");

    a_stall_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_held_result_blocks_tick : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && r_in_valid && (r_item.kind == tspi_pkg::KIND_TICK))
            |-> o_stall)
        else $error("tick processed while a result was still held");

    a_result_from_tick : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || !i_stall) && !w_tick_fire |=> !o_valid)
        else $error("result beat appeared without a tick");

endmodule
